// ===== rtl/lrukv_pkg.sv =====
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared types and constants for the fully associative LRU key/value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lrukv_pkg;

    // port widths fixed by the interface
    localparam int KEY_PORT_BITS = 32;
    localparam int DATA_BITS     = 32;
    localparam int CAP_BITS      = 5;

    // default sizing
    localparam int ENTRIES_DEFAULT  = 16;
    localparam int KEY_BITS_DEFAULT = 32;

    // capacity register value after reset
    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = CAP_BITS'(16);

    // value returned by a get that misses
    localparam logic [DATA_BITS-1:0] MISS_VALUE = '1;

    // request kind
    typedef enum logic [0:0] {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    // request held in the input stage
    typedef struct packed {
        op_t                        op;
        logic [KEY_PORT_BITS-1:0]   key;
        logic [DATA_BITS-1:0]       data;
    } req_t;

    // lookup answer for a get
    typedef struct packed {
        logic                   hit;
        logic [DATA_BITS-1:0]   data;
    } resp_t;

endpackage

`default_nettype wire

// ===== rtl/lrukv_store.sv =====
// ----------------------------------------------------------------------------
// lrukv_store
// Entry array with parallel key compare, rank based recency and the single
// pass update for one request (hit, fill of a free entry, or eviction).
// ----------------------------------------------------------------------------
`default_nettype none

module lrukv_store #(
    parameter int ENTRIES  = lrukv_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS = lrukv_pkg::KEY_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               commit,
    input  wire lrukv_pkg::req_t                    req,
    input  wire logic [lrukv_pkg::CAP_BITS-1:0]     capacity,
    output      lrukv_pkg::resp_t                   resp
);

    localparam int SK_BITS = (KEY_BITS < lrukv_pkg::KEY_PORT_BITS) ?
                             KEY_BITS : lrukv_pkg::KEY_PORT_BITS;
    localparam int RANK_W  = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (CNT_W > lrukv_pkg::CAP_BITS) ? CNT_W : lrukv_pkg::CAP_BITS;

    // entry storage
    logic [ENTRIES-1:0]                 valid_reg;
    logic [ENTRIES-1:0]                 valid_next;
    logic [RANK_W-1:0]                  rank_reg  [ENTRIES];
    logic [RANK_W-1:0]                  rank_next [ENTRIES];
    logic [SK_BITS-1:0]                 key_mem   [ENTRIES];
    logic [lrukv_pkg::DATA_BITS-1:0]    value_mem [ENTRIES];
    logic [CNT_W-1:0]                   used_reg;
    logic [CNT_W-1:0]                   used_next;

    logic [SK_BITS-1:0]                 req_key;
    logic [ENTRIES-1:0]                 match;
    logic [ENTRIES-1:0]                 free_oh;
    logic [ENTRIES-1:0]                 victim_oh;
    logic [ENTRIES-1:0]                 target_oh;
    logic                               hit;
    logic [RANK_W-1:0]                  hit_rank;
    logic [lrukv_pkg::DATA_BITS-1:0]    hit_value;
    logic [CMP_W-1:0]                   cap_ext;
    logic [CMP_W-1:0]                   eff_cap;
    logic                               alloc;
    logic [CNT_W-1:0]                   used_m1;
    logic [CNT_W-1:0]                   threshold;
    logic                               is_put;
    logic                               do_touch;

    assign req_key = req.key[SK_BITS-1:0];
    assign is_put  = (req.op == lrukv_pkg::OP_PUT);
    assign used_m1 = used_reg - CNT_W'(1);

    // parallel key compare and hit selection
    always_comb
    begin
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]  = valid_reg[i] && (key_mem[i] == req_key);
            victim_oh[i] = valid_reg[i] && (rank_reg[i] == used_m1[RANK_W-1:0]);
            if (match[i])
            begin
                hit_rank  = hit_rank | rank_reg[i];
                hit_value = hit_value | value_mem[i];
            end
        end
        hit = |match;
    end

    // lowest free entry
    assign free_oh = ~valid_reg & (valid_reg + ENTRIES'(1));

    // effective capacity, clamped to 1..ENTRIES
    always_comb
    begin
        cap_ext = CMP_W'(capacity);
        if (cap_ext == '0)
            eff_cap = CMP_W'(1);
        else if (cap_ext > CMP_W'(ENTRIES))
            eff_cap = CMP_W'(ENTRIES);
        else
            eff_cap = cap_ext;
    end

    assign alloc = !hit && (CMP_W'(used_reg) < eff_cap) && (used_reg != CNT_W'(ENTRIES));

    // entry to make most recent and the rank below which entries age
    always_comb
    begin
        if (hit)
        begin
            target_oh = match;
            threshold = CNT_W'(hit_rank);
        end
        else if (alloc)
        begin
            target_oh = free_oh;
            threshold = used_reg;
        end
        else
        begin
            target_oh = victim_oh;
            threshold = used_m1;
        end
    end

    assign do_touch = commit && (is_put || hit);

    // next state of valid bits, ranks and fill count
    always_comb
    begin
        valid_next = valid_reg;
        used_next  = used_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (do_touch)
            begin
                if (target_oh[i])
                    rank_next[i] = '0;
                else if (valid_reg[i] && (CNT_W'(rank_reg[i]) < threshold))
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
            end
        end
        if (commit && is_put && alloc)
        begin
            valid_next = valid_reg | free_oh;
            used_next  = used_reg + CNT_W'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            used_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= rank_next[i];
        end
    end

    // key and value storage, written by a put
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (commit && is_put && target_oh[i])
            begin
                key_mem[i]   <= req_key;
                value_mem[i] <= req.data;
            end
        end
    end

    // answer for a get
    always_comb
    begin
        resp.hit  = hit;
        resp.data = hit ? hit_value : lrukv_pkg::MISS_VALUE;
    end

endmodule

`default_nettype wire

// ===== rtl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least recently used replacement.
// ----------------------------------------------------------------------------
// path: a get is held in the input register, then its result is written to the
//   result register when it advances, and waits there until taken
// throughput: one transaction per cycle until a result not taken holds a get;
//   the input and result registers are the only stages, the whole lookup and
//   update sits between; puts return nothing, never waiting in the input stage
// reset: all entries invalid, ranks and fill count zero, capacity 16
`default_nettype none

module lru_key_value_cache #(
    parameter int ENTRIES  = lrukv_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS = lrukv_pkg::KEY_BITS_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration
    input  wire logic                                   cfg_we,
    input  wire logic [lrukv_pkg::CAP_BITS-1:0]         cfg_data,
    // request channel
    input  wire logic                                   in_valid,
    output      logic                                   in_ready,
    input  wire logic                                   op,
    input  wire logic signed [lrukv_pkg::KEY_PORT_BITS-1:0] key,
    input  wire logic signed [lrukv_pkg::DATA_BITS-1:0] data_in,
    // result channel
    output      logic                                   out_valid,
    input  wire logic                                   out_ready,
    output      logic                                   hit,
    output      logic signed [lrukv_pkg::DATA_BITS-1:0] data_out
);

    logic [lrukv_pkg::CAP_BITS-1:0]     capacity_reg;
    logic                               s1_valid_reg;
    lrukv_pkg::req_t                    s1_req_reg;
    logic                               out_valid_reg;
    logic                               out_hit_reg;
    logic [lrukv_pkg::DATA_BITS-1:0]    out_data_reg;
    lrukv_pkg::resp_t                   resp;
    logic                               s1_is_get;
    logic                               advance;
    logic                               in_fire;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= lrukv_pkg::CAPACITY_RESET;
        else if (cfg_we)
            capacity_reg <= cfg_data;
    end

    // handshake: a put always leaves, a get needs room in the result register
    assign s1_is_get = (s1_req_reg.op == lrukv_pkg::OP_GET);
    assign advance   = s1_valid_reg && (!s1_is_get || !out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_req_reg.op   <= lrukv_pkg::op_t'(op);
            s1_req_reg.key  <= key;
            s1_req_reg.data <= data_in;
        end
    end

    // entry array and lookup
    lrukv_store #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .commit   (advance),
        .req      (s1_req_reg),
        .capacity (capacity_reg),
        .resp     (resp)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && s1_is_get)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_is_get)
        begin
            out_hit_reg  <= resp.hit;
            out_data_reg <= resp.data;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign data_out  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/lrukv_checker.sv =====
// ----------------------------------------------------------------------------
// lrukv_checker
// Port level checks on the LRU key/value cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lrukv_checker (
    input wire logic                                    clk,
    input wire logic                                    rst_n,
    input wire logic                                    in_valid,
    input wire logic                                    in_ready,
    input wire logic                                    op,
    input wire logic [lrukv_pkg::KEY_PORT_BITS-1:0]     key,
    input wire logic [lrukv_pkg::DATA_BITS-1:0]         data_in,
    input wire logic                                    out_valid,
    input wire logic                                    out_ready,
    input wire logic                                    hit,
    input wire logic [lrukv_pkg::DATA_BITS-1:0]         data_out
);

    logic acc_get;
    logic acc_put;

    assign acc_get = in_valid && in_ready && (op == lrukv_pkg::OP_GET);
    assign acc_put = in_valid && in_ready && (op == lrukv_pkg::OP_PUT);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(data_out))
        else $error("result changed while stalled");

    // a miss always reports all ones
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> data_out == lrukv_pkg::MISS_VALUE)
        else $error("miss with data other than all ones");

    // a new result needs a get accepted earlier
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(acc_get, 2))
        else $error("result without a get transaction");

    // a get straight after a put of the same key hits with the stored value
    a_put_then_get: assert property (@(posedge clk) disable iff (!rst_n)
        acc_put ##1 (acc_get && key == $past(key) && !out_valid)
        |-> ##2 (out_valid && hit && data_out == $past(data_in, 3)))
        else $error("get after put did not return the stored value");

endmodule

bind lru_key_value_cache lrukv_checker u_lrukv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .key       (key),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .data_out  (data_out)
);

`default_nettype wire
